// ===== sv/hpa_pkg.sv =====
// Shared types, constants and arithmetic helpers for the HSL pixel adjust unit.
// No dependencies; every other file of the block refers to this package.
package hpa_pkg;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;

    // One quotient bit is produced per divider stage.
    localparam int DIV_STEPS = 8;

    // Configuration register indexes.
    localparam logic [1:0] REG_HUE_OFFSET = 2'd0;
    localparam logic [1:0] REG_SAT_GAIN   = 2'd1;
    localparam logic [1:0] REG_LIGHT_GAIN = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [8:0] HUE_OFFSET_RESET = 9'd0;
    localparam logic [9:0] GAIN_UNITY       = 10'd256;

    // Reciprocal of 15 scaled by two to the RECIP_SHIFT, rounded up.
    localparam logic [21:0] RECIP15     = 22'd2236963;
    localparam int          RECIP_SHIFT = 25;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
        logic [7:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
        logic [7:0] alpha_out;
    } pixel_out_t;

    typedef struct packed {
        logic signed [8:0] hue_offset;
        logic [9:0]        saturation_gain;
        logic [9:0]        lightness_gain;
    } cfg_t;

    // Classified pixel as it leaves the front part.
    typedef struct packed {
        logic [12:0] hnum;   // magnitude of the hue numerator
        logic [7:0]  hden;   // hue divisor (chroma), 1 for grey
        logic        hneg;   // hue quotient is subtracted
        logic [7:0]  hbase;  // sector base of the hue
        logic [15:0] snum;   // saturation numerator
        logic [8:0]  sden;   // saturation divisor
        logic        szero;  // saturation is zero
        logic [7:0]  light;  // lightness
        logic [7:0]  alpha;
    } front_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // One restoring division step: returns the new remainder and the quotient bit.
    function automatic logic [9:0] div_step(input logic [8:0] rem, input logic din,
                                            input logic [8:0] den);
        logic [9:0] t;
        logic [9:0] diff;
        t    = {rem, din};
        diff = t - {1'b0, den};
        if (t >= {1'b0, den})
        begin
            return {diff[8:0], 1'b1};
        end
        return {t[8:0], 1'b0};
    endfunction

    // Gain numerator: pushes x toward 255 above unity, toward 0 at or below it.
    function automatic logic [18:0] gain_mul(input logic [7:0] x, input logic [9:0] g);
        logic [9:0] gx;
        logic [7:0] inv;
        gx  = g - GAIN_UNITY;
        inv = 8'd255 - x;
        if (g > GAIN_UNITY)
        begin
            return 19'({x, 8'd0}) + 19'(gx) * 19'(inv);
        end
        return 19'(g) * 19'(x);
    endfunction

endpackage

// ===== sv/hsl_pixel_adjust_unit.sv =====
// Throughput: one pixel per clock; the back pipeline advances unless a result waits unread.
// The 8-stage bit-per-stage divider for hue and saturation sets most of the latency.
// Reset (rst_n, asynchronous, active low) empties the queue and pipeline at once and
// sets hue_offset to 0 and both gains to 256; no clearing pass is needed.
// Top level: configuration registers, front part, queue and back pipeline; uses hpa_pkg.
module hsl_pixel_adjust_unit #(
    parameter int QUEUE_DEPTH = hpa_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  hpa_pkg::pixel_in_t   item,
    output logic                 empty,
    input  logic                 pop,
    output hpa_pkg::pixel_out_t  result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [9:0]           cfg_data
);

    hpa_pkg::cfg_t         cfg_reg, cfg_next;
    hpa_pkg::q_status_t    qst;
    hpa_pkg::front_item_t  q_wr, q_head;
    logic                  q_push, q_pop;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                hpa_pkg::REG_HUE_OFFSET: cfg_next.hue_offset      = $signed(cfg_data[8:0]);
                hpa_pkg::REG_SAT_GAIN:   cfg_next.saturation_gain = cfg_data;
                hpa_pkg::REG_LIGHT_GAIN: cfg_next.lightness_gain  = cfg_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hue_offset      <= $signed(hpa_pkg::HUE_OFFSET_RESET);
            cfg_reg.saturation_gain <= hpa_pkg::GAIN_UNITY;
            cfg_reg.lightness_gain  <= hpa_pkg::GAIN_UNITY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hpa_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .qst    (qst),
        .q_push (q_push),
        .q_data (q_wr)
    );

    hpa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_head),
        .st      (qst)
    );

    hpa_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .qst    (qst),
        .head   (q_head),
        .q_pop  (q_pop),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== sv/hpa_front.sv =====
// Front part: takes pixels, finds max, min and sector, and sets up both divisions.
// Depends on hpa_pkg.
module hpa_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  hpa_pkg::pixel_in_t     item,
    input  hpa_pkg::q_status_t     qst,
    output logic                   q_push,
    output hpa_pkg::front_item_t   q_data
);

    logic [7:0]            b, g, r;
    logic [7:0]            mx, mn, d, mag;
    logic [8:0]            sum9;
    logic                  accept;
    logic                  f_vld_reg, f_vld_next;
    hpa_pkg::front_item_t  cls;
    hpa_pkg::front_item_t  f_item_reg;

    assign b = item.blue_in;
    assign g = item.green_in;
    assign r = item.red_in;

    // Extremes and chroma.
    always_comb
    begin
        mx = b;
        mn = b;
        if (g > mx) mx = g;
        if (g < mn) mn = g;
        if (r > mx) mx = r;
        if (r < mn) mn = r;
        d    = mx - mn;
        sum9 = {1'b0, mx} + {1'b0, mn};
    end

    // Hue sector and the operands of both divisions.
    always_comb
    begin
        mag        = 8'd0;
        cls.hneg   = 1'b0;
        cls.hbase  = 8'd0;
        cls.hden   = 8'd1;
        if (d != 8'd0)
        begin
            cls.hden = d;
            if (mx == r)
            begin
                if (g >= b)
                begin
                    mag = g - b;
                end
                else
                begin
                    mag       = b - g;
                    cls.hneg  = 1'b1;
                    cls.hbase = 8'd180;
                end
            end
            else if (mx == g)
            begin
                cls.hbase = 8'd60;
                if (b >= r) mag = b - r;
                else
                begin
                    mag      = r - b;
                    cls.hneg = 1'b1;
                end
            end
            else
            begin
                cls.hbase = 8'd120;
                if (r >= g) mag = r - g;
                else
                begin
                    mag      = g - r;
                    cls.hneg = 1'b1;
                end
            end
        end
        cls.hnum  = 13'(mag) * 13'd30;
        cls.light = sum9[8:1];
        cls.szero = (sum9[8:1] == 8'd0) || (d == 8'd0);
        cls.sden  = (sum9[8:1] <= 8'd127) ? sum9 : (9'd510 - sum9);
        cls.snum  = 16'(d) * 16'd255;
        cls.alpha = item.alpha_in;
    end

    // The front register hands its item to the queue as soon as there is room.
    assign q_push     = f_vld_reg && !qst.full;
    assign full       = f_vld_reg && qst.full;
    assign accept     = push && !full;
    assign f_vld_next = accept || (f_vld_reg && !q_push);
    assign q_data     = f_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else
        begin
            f_vld_reg <= f_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_item_reg <= cls;
        end
    end

endmodule

// ===== sv/hpa_queue.sv =====
// Short queue that decouples the front part from the back pipeline.
// Depends on hpa_pkg.
module hpa_queue #(
    parameter int DEPTH = hpa_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  hpa_pkg::front_item_t  wr_data,
    input  logic                  pop,
    output hpa_pkg::front_item_t  rd_data,
    output hpa_pkg::q_status_t    st
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hpa_pkg::front_item_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  do_push, do_pop;

    assign st.full  = (count_reg == CNT_W'(DEPTH));
    assign st.empty = (count_reg == '0);
    assign do_push  = push && !st.full;
    assign do_pop   = pop && !st.empty;
    assign rd_data  = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !st.full)
        else $error("queue written while full");
`endif

endmodule

// ===== sv/hpa_back.sv =====
// Back pipeline: hue and saturation dividers, hue shift, gains and HSL to BGR conversion.
// Depends on hpa_pkg.
module hpa_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  hpa_pkg::cfg_t         cfg,
    input  hpa_pkg::q_status_t    qst,
    input  hpa_pkg::front_item_t  head,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output hpa_pkg::pixel_out_t   result
);

    localparam int NSTAGE = hpa_pkg::DIV_STEPS + 7;

    typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} seg_t;

    typedef struct packed {
        logic [8:0] hrem;
        logic [7:0] hbits;
        logic [7:0] hden;
        logic       hneg;
        logic [7:0] hbase;
        logic [8:0] srem;
        logic [7:0] sbits;
        logic [8:0] sden;
        logic       szero;
        logic [7:0] light;
        logic [7:0] alpha;
    } div_stage_t;

    logic [NSTAGE-1:0] vld_reg;
    logic              en;

    div_stage_t div_in  [hpa_pkg::DIV_STEPS];
    div_stage_t div_reg [hpa_pkg::DIV_STEPS];

    // Whole pipeline moves together; it stops only while a finished result waits.
    assign en    = !vld_reg[NSTAGE-1] || pop;
    assign q_pop = en && !qst.empty;
    assign empty = !vld_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NSTAGE-2:0], !qst.empty};
        end
    end

    // Divider stages: one hue and one saturation quotient bit per stage.
    always_comb
    begin
        div_in[0].hrem  = {4'd0, head.hnum[12:8]};
        div_in[0].hbits = head.hnum[7:0];
        div_in[0].hden  = head.hden;
        div_in[0].hneg  = head.hneg;
        div_in[0].hbase = head.hbase;
        div_in[0].srem  = {1'b0, head.snum[15:8]};
        div_in[0].sbits = head.snum[7:0];
        div_in[0].sden  = head.sden;
        div_in[0].szero = head.szero;
        div_in[0].light = head.light;
        div_in[0].alpha = head.alpha;
        for (int i = 1; i < hpa_pkg::DIV_STEPS; i++)
        begin
            div_in[i] = div_reg[i-1];
        end
    end

    for (genvar gi = 0; gi < hpa_pkg::DIV_STEPS; gi++)
    begin : g_div
        logic [9:0] hstep, sstep;
        div_stage_t nxt;

        assign hstep = hpa_pkg::div_step(div_in[gi].hrem, div_in[gi].hbits[7],
                                         {1'b0, div_in[gi].hden});
        assign sstep = hpa_pkg::div_step(div_in[gi].srem, div_in[gi].sbits[7],
                                         div_in[gi].sden);

        always_comb
        begin
            nxt       = div_in[gi];
            nxt.hrem  = hstep[9:1];
            nxt.hbits = {div_in[gi].hbits[6:0], hstep[0]};
            nxt.srem  = sstep[9:1];
            nxt.sbits = {div_in[gi].sbits[6:0], sstep[0]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[gi] <= nxt;
            end
        end
    end

    // Stage A: hue with offset wrapped into 0..179, gain products.
    div_stage_t          dq;
    logic signed [9:0]   hq_s, hval;
    logic signed [10:0]  hsum, hw1, hw2;
    logic [7:0]          sat;
    logic [7:0]          a_hue_reg;
    logic [18:0]         a_lprod_reg, a_sprod_reg;
    logic [7:0]          a_alpha_reg;

    function automatic logic signed [10:0] wrap180(input logic signed [10:0] v);
        if (v < 0)
        begin
            return v + 11'sd180;
        end
        if (v >= 11'sd180)
        begin
            return v - 11'sd180;
        end
        return v;
    endfunction

    always_comb
    begin
        dq   = div_reg[hpa_pkg::DIV_STEPS-1];
        hq_s = $signed({2'b00, dq.hbits});
        hval = $signed({2'b00, dq.hbase}) + (dq.hneg ? -hq_s : hq_s);
        hsum = $signed({hval[9], hval}) +
               $signed({{2{cfg.hue_offset[8]}}, cfg.hue_offset});
        hw1  = wrap180(hsum);
        hw2  = wrap180(hw1);
        sat  = dq.szero ? 8'd0 : dq.sbits;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_hue_reg   <= hw2[7:0];
            a_lprod_reg <= hpa_pkg::gain_mul(dq.light, cfg.lightness_gain);
            a_sprod_reg <= hpa_pkg::gain_mul(sat, cfg.saturation_gain);
            a_alpha_reg <= dq.alpha;
        end
    end

    // Stage B: scale and clamp the adjusted lightness and saturation.
    logic [7:0] b_ls_reg, b_ss_reg, b_hue_reg, b_alpha_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ls_reg    <= (a_lprod_reg[18:8] > 11'd255) ? 8'd255 : a_lprod_reg[15:8];
            b_ss_reg    <= (a_sprod_reg[18:8] > 11'd255) ? 8'd255 : a_sprod_reg[15:8];
            b_hue_reg   <= a_hue_reg;
            b_alpha_reg <= a_alpha_reg;
        end
    end

    // Stage C: upper level of the back-conversion.
    logic [17:0] hi_w;
    logic [15:0] c_hi_reg;
    logic [7:0]  c_ls_reg, c_hue_reg, c_alpha_reg;
    logic        c_grey_reg;

    always_comb
    begin
        if (b_ls_reg < 8'd127)
        begin
            hi_w = 18'(b_ls_reg) * (18'(b_ss_reg) + 18'd255);
        end
        else
        begin
            hi_w = (18'(b_ls_reg) + 18'(b_ss_reg)) * 18'd255
                   - 18'(b_ls_reg) * 18'(b_ss_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_hi_reg    <= hi_w[15:0];
            c_ls_reg    <= b_ls_reg;
            c_grey_reg  <= (b_ss_reg == 8'd0);
            c_hue_reg   <= b_hue_reg;
            c_alpha_reg <= b_alpha_reg;
        end
    end

    // Stage D: lower level, level spread, and the sector of each channel.
    logic [17:0]         l510;
    logic [17:0]         dh_w;
    logic [7:0]          chue [3];
    seg_t                seg_w [3];
    logic [4:0]          t_w [3];
    logic signed [17:0]  d_lo_reg;
    logic [15:0]         d_dh_reg, d_hi_reg;
    logic [7:0]          d_ls_reg, d_alpha_reg;
    logic                d_grey_reg;
    seg_t                d_seg_reg [3];
    logic [4:0]          d_t_reg [3];

    always_comb
    begin
        l510    = 18'(c_ls_reg) * 18'd510;
        dh_w    = 18'({c_hi_reg, 1'b0}) - l510;
        // Blue sits 60 below, red 60 above the shifted hue.
        chue[0] = (c_hue_reg < 8'd60) ? c_hue_reg + 8'd120 : c_hue_reg - 8'd60;
        chue[1] = c_hue_reg;
        chue[2] = (c_hue_reg >= 8'd120) ? c_hue_reg - 8'd120 : c_hue_reg + 8'd60;
        for (int k = 0; k < 3; k++)
        begin
            t_w[k] = 5'd0;
            if (chue[k] < 8'd30)
            begin
                seg_w[k] = SEG_RISE;
                t_w[k]   = chue[k][4:0];
            end
            else if (chue[k] < 8'd90)
            begin
                seg_w[k] = SEG_HIGH;
            end
            else if (chue[k] < 8'd120)
            begin
                seg_w[k] = SEG_FALL;
                t_w[k]   = 5'(8'd120 - chue[k]);
            end
            else
            begin
                seg_w[k] = SEG_LOW;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_lo_reg    <= $signed(l510) - $signed({2'b00, c_hi_reg});
            d_dh_reg    <= dh_w[15:0];
            d_hi_reg    <= c_hi_reg;
            d_ls_reg    <= c_ls_reg;
            d_grey_reg  <= c_grey_reg;
            d_alpha_reg <= c_alpha_reg;
            for (int k = 0; k < 3; k++)
            begin
                d_seg_reg[k] <= seg_w[k];
                d_t_reg[k]   <= t_w[k];
            end
        end
    end

    // Stage E: spread times position within the ramp.
    logic signed [17:0]  e_lo_reg;
    logic [15:0]         e_hi_reg;
    logic [7:0]          e_ls_reg, e_alpha_reg;
    logic                e_grey_reg;
    seg_t                e_seg_reg [3];
    logic [20:0]         e_prod_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_lo_reg    <= d_lo_reg;
            e_hi_reg    <= d_hi_reg;
            e_ls_reg    <= d_ls_reg;
            e_grey_reg  <= d_grey_reg;
            e_alpha_reg <= d_alpha_reg;
            for (int k = 0; k < 3; k++)
            begin
                e_seg_reg[k]  <= d_seg_reg[k];
                e_prod_reg[k] <= 21'(d_dh_reg) * 21'(d_t_reg[k]);
            end
        end
    end

    // Stage F: divide by 30 as a halving and a reciprocal multiply by 1/15.
    logic [41:0]         recip_w [3];
    logic signed [17:0]  f_lo_reg;
    logic [15:0]         f_hi_reg;
    logic [7:0]          f_ls_reg, f_alpha_reg;
    logic                f_grey_reg;
    seg_t                f_seg_reg [3];
    logic [15:0]         f_q_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            recip_w[k] = 42'(e_prod_reg[k][20:1]) * 42'(hpa_pkg::RECIP15);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_lo_reg    <= e_lo_reg;
            f_hi_reg    <= e_hi_reg;
            f_ls_reg    <= e_ls_reg;
            f_grey_reg  <= e_grey_reg;
            f_alpha_reg <= e_alpha_reg;
            for (int k = 0; k < 3; k++)
            begin
                f_seg_reg[k] <= e_seg_reg[k];
                f_q_reg[k]   <= recip_w[k][hpa_pkg::RECIP_SHIFT +: 16];
            end
        end
    end

    // Stage G: channel level, floor at zero, divide by 255, output register.
    logic signed [17:0]  lvl [3];
    logic [15:0]         lvl_u [3];
    logic [16:0]         div255 [3];
    logic [7:0]          chan [3];
    hpa_pkg::pixel_out_t out_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            case (f_seg_reg[k])
                SEG_RISE, SEG_FALL: lvl[k] = f_lo_reg + $signed({2'b00, f_q_reg[k]});
                SEG_HIGH:           lvl[k] = $signed({2'b00, f_hi_reg});
                SEG_LOW:            lvl[k] = f_lo_reg;
                default:            lvl[k] = f_lo_reg;
            endcase
            lvl_u[k]  = (lvl[k] < 0) ? 16'd0 : lvl[k][15:0];
            div255[k] = 17'(lvl_u[k]) + 17'(lvl_u[k][15:8]) + 17'd1;
            chan[k]   = f_grey_reg ? f_ls_reg : div255[k][15:8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg.blue_out  <= chan[0];
            out_reg.green_out <= chan[1];
            out_reg.red_out   <= chan[2];
            out_reg.alpha_out <= f_alpha_reg;
        end
    end

    assign result = out_reg;

`ifndef ASSERT_OFF
    a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
        (en && vld_reg[NSTAGE-2] && f_grey_reg) |=>
        (result.blue_out == result.green_out) && (result.green_out == result.red_out))
        else $error("grey pixel left with unequal channels");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NSTAGE-1] && !pop) |=> (vld_reg[NSTAGE-1] && $stable(out_reg)))
        else $error("waiting result lost or changed");
`endif

endmodule
